// File: design/fps_pkg.sv
// fps_pkg: shared constants, types and register codes for the flyby periapse state block.
// No dependencies; imported by fps_sqrt, fps_unit, flyby_periapse_state and tb_top.
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

    // field widths
    localparam int V_W    = 32;   // Q16.16 velocity
    localparam int POS_W  = 48;   // Q32.16 position
    localparam int CFG_W  = 28;   // widest config register
    localparam int IDX_W  = 2;
    localparam int GP_W   = 28;
    localparam int RAD_W  = 24;
    localparam int VEC_W  = 64;   // signed vector component fed to a unitizer
    localparam int UNIT_W = 32;   // signed Q1.30 unit component

    // config register indexes
    localparam logic [IDX_W-1:0] CFG_GRAV_PARAM = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BODY_RAD   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FLYBY_ALT  = 2'd2;

    localparam logic [GP_W-1:0]  GRAV_PARAM_RST = 28'd398600;
    localparam logic [RAD_W-1:0] BODY_RAD_RST   = 24'd6378;
    localparam logic [RAD_W-1:0] FLYBY_ALT_RST  = 24'd300;

    // status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_DEGEN = 2'd1;
    localparam t_status ST_CLAMP = 2'd2;

    // gravity term divider sequencer
    typedef enum logic [1:0] {
        G_LOAD,
        G_RUN,
        G_IDLE
    } t_gstate;

    // pipeline geometry
    localparam int NORM_STG = 6;                // shifts of 32,16,8,4,2,1
    localparam int SQRT_W   = 64;               // radicand width
    localparam int SQRT_LAT = SQRT_W / 2;       // one root bit per stage
    localparam int DIV_STG  = 31;               // one quotient bit per stage
    localparam int UNIT_LAT = 1 + NORM_STG + 2 + SQRT_LAT + 1 + DIV_STG + 1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

endpackage
`default_nettype wire

// File: design/flyby_periapse_state.sv
// flyby_periapse_state: top level, periapse position and velocity from excess velocities.
// Depends on fps_pkg, fps_unit and fps_sqrt.
// One transaction per cycle sustained while busy is low.
// The path from an accepted start to o_done runs through three chained unitizers (each a
// 32-stage square root and 31-stage divider) plus cross-product and output scaling stages.
// After reset and after every config write, busy is high while the gravity term is
// divided out one quotient bit per cycle; no start is taken then.
// Reset (synchronous, active low) clears the valid pipeline and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module flyby_periapse_state (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [fps_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [fps_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [fps_pkg::V_W-1:0]    i_vin_x,
    input  logic signed [fps_pkg::V_W-1:0]    i_vin_y,
    input  logic signed [fps_pkg::V_W-1:0]    i_vin_z,
    input  logic signed [fps_pkg::V_W-1:0]    i_vout_x,
    input  logic signed [fps_pkg::V_W-1:0]    i_vout_y,
    input  logic signed [fps_pkg::V_W-1:0]    i_vout_z,
    output logic                              o_done,
    output logic signed [fps_pkg::POS_W-1:0]  o_peri_pos_x,
    output logic signed [fps_pkg::POS_W-1:0]  o_peri_pos_y,
    output logic signed [fps_pkg::POS_W-1:0]  o_peri_pos_z,
    output logic signed [fps_pkg::V_W-1:0]    o_peri_vel_x,
    output logic signed [fps_pkg::V_W-1:0]    o_peri_vel_y,
    output logic signed [fps_pkg::V_W-1:0]    o_peri_vel_z,
    output logic [1:0]                        o_status
);
    import fps_pkg::*;

    // pipeline timing, cycle 0 = input registers loaded
    localparam int T_U1  = UNIT_LAT;              // unit vin / unit vout
    localparam int T_C1  = T_U1 + 2;              // d and vin x vout ready
    localparam int T_U2  = T_C1 + UNIT_LAT;       // p and unit h
    localparam int T_C2  = T_U2 + 2;              // h x p ready
    localparam int T_U3  = T_C2 + UNIT_LAT;       // velocity direction
    localparam int T_OUT = T_U3 + 2;              // output registers
    localparam int T_ARG = 2;                     // root argument registered
    localparam int T_SPD = T_ARG + SQRT_LAT + 1;  // saturated speed registered
    localparam int GQ_W  = GP_W + 33;             // gravity numerator / quotient width
    localparam int GC_W  = $clog2(GQ_W);

    //--------------------------------------------------------------------
    // Config registers
    //--------------------------------------------------------------------
    logic [GP_W-1:0]  r_grav_param;
    logic [RAD_W-1:0] r_body_rad;
    logic [RAD_W-1:0] r_flyby_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_param <= GRAV_PARAM_RST;
            r_body_rad   <= BODY_RAD_RST;
            r_flyby_alt  <= FLYBY_ALT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRAV_PARAM: r_grav_param <= i_cfg_data[GP_W-1:0];
                CFG_BODY_RAD:   r_body_rad   <= i_cfg_data[RAD_W-1:0];
                CFG_FLYBY_ALT:  r_flyby_alt  <= i_cfg_data[RAD_W-1:0];
                default:        ;   // unknown index: write dropped
            endcase
        end
    end

    // periapse radius r = body radius + altitude
    logic [RAD_W:0] w_rad;
    logic [RAD_W:0] w_gdiv;
    assign w_rad  = {1'b0, r_body_rad} + {1'b0, r_flyby_alt};
    assign w_gdiv = (w_rad == '0) ? (RAD_W+1)'(1) : w_rad;

    //--------------------------------------------------------------------
    // Gravity term floor(2*mu*2^32 / r): serial restoring divide,
    // rerun after reset and after each config write
    //--------------------------------------------------------------------
    t_gstate         r_gstate, n_gstate;
    logic [GC_W-1:0] r_gcnt,   n_gcnt;
    logic [RAD_W:0]  r_grem,   n_grem;
    logic [GQ_W-1:0] r_gq,     n_gq;
    logic [RAD_W+1:0] w_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gstate <= G_LOAD;
            r_gcnt   <= '0;
        end else begin
            r_gstate <= n_gstate;
            r_gcnt   <= n_gcnt;
        end
        r_grem <= n_grem;
        r_gq   <= n_gq;
    end

    always_comb begin
        n_gstate = r_gstate;
        n_gcnt   = r_gcnt;
        n_grem   = r_grem;
        n_gq     = r_gq;
        w_gt     = {r_grem, r_gq[GQ_W-1]};
        unique case (r_gstate)
            G_LOAD: begin
                n_gq     = {r_grav_param, 33'b0};
                n_grem   = '0;
                n_gcnt   = '0;
                n_gstate = G_RUN;
            end
            G_RUN: begin
                if (w_gt >= {1'b0, w_gdiv}) begin
                    n_grem = (RAD_W+1)'(w_gt - {1'b0, w_gdiv});
                    n_gq   = {r_gq[GQ_W-2:0], 1'b1};
                end else begin
                    n_grem = w_gt[RAD_W:0];
                    n_gq   = {r_gq[GQ_W-2:0], 1'b0};
                end
                n_gcnt = r_gcnt + GC_W'(1);
                if (r_gcnt == GC_W'(GQ_W - 1)) n_gstate = G_IDLE;
            end
            G_IDLE: ;
            default: n_gstate = G_LOAD;
        endcase
        if (i_cfg_we) n_gstate = G_LOAD;
    end

    assign busy = (r_gstate != G_IDLE);

    //--------------------------------------------------------------------
    // Input capture and valid pipeline
    //--------------------------------------------------------------------
    logic                    w_acc;
    logic [T_OUT:0]          r_vld;
    logic signed [V_W-1:0]   r_vi [3];
    logic signed [V_W-1:0]   r_vo [3];

    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[T_OUT-1:0], w_acc};
        if (w_acc) begin
            r_vi[0] <= i_vin_x;  r_vi[1] <= i_vin_y;  r_vi[2] <= i_vin_z;
            r_vo[0] <= i_vout_x; r_vo[1] <= i_vout_y; r_vo[2] <= i_vout_z;
        end
    end

    //--------------------------------------------------------------------
    // Speed path: vin.vout + grav term, then square root
    //--------------------------------------------------------------------
    logic signed [63:0] r_dot [3];
    logic signed [63:0] r_arg;
    logic [63:0]        w_srad;
    logic [31:0]        w_root;
    logic [30:0]        r_spd;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) r_dot[i] <= r_vi[i] * r_vo[i];
        // each term floored by 4 before the sum
        r_arg <= $signed({5'b0, r_gq[GQ_W-1:2]}) + (r_dot[0] >>> 2)
                 + (r_dot[1] >>> 2) + (r_dot[2] >>> 2);
        r_spd <= w_root[31] ? 31'h7FFF_FFFF : w_root[30:0];
    end

    assign w_srad = r_arg[63] ? '0 : {r_arg[61:0], 2'b00};

    fps_sqrt #(.W(SQRT_W)) u_spd_sqrt (
        .i_clk  (i_clk),
        .i_rad  (w_srad),
        .o_root (w_root)
    );

    //--------------------------------------------------------------------
    // Unit vin, unit vout
    //--------------------------------------------------------------------
    logic signed [VEC_W-1:0]  w_c1 [3];
    logic signed [VEC_W-1:0]  w_c2 [3];
    logic signed [UNIT_W-1:0] w_ui [3];
    logic signed [UNIT_W-1:0] w_uo [3];
    logic                     w_ok1, w_ok2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c1[i] = VEC_W'(r_vi[i]);
            w_c2[i] = VEC_W'(r_vo[i]);
        end
    end

    fps_unit u_unit_in  (.i_clk(i_clk), .i_c(w_c1), .o_u(w_ui), .o_ok(w_ok1));
    fps_unit u_unit_out (.i_clk(i_clk), .i_c(w_c2), .o_u(w_uo), .o_ok(w_ok2));

    // d = ui - uo and h = ui x uo
    logic signed [VEC_W-1:0] r_hp [6];
    logic signed [VEC_W-1:0] r_h  [3];
    logic signed [VEC_W-1:0] r_d  [3];
    logic signed [VEC_W-1:0] r_d2 [3];
    logic                    r_ok12, r_ok12b;

    always_ff @(posedge i_clk) begin
        r_hp[0] <= VEC_W'(w_ui[1]) * VEC_W'(w_uo[2]);
        r_hp[1] <= VEC_W'(w_ui[2]) * VEC_W'(w_uo[1]);
        r_hp[2] <= VEC_W'(w_ui[2]) * VEC_W'(w_uo[0]);
        r_hp[3] <= VEC_W'(w_ui[0]) * VEC_W'(w_uo[2]);
        r_hp[4] <= VEC_W'(w_ui[0]) * VEC_W'(w_uo[1]);
        r_hp[5] <= VEC_W'(w_ui[1]) * VEC_W'(w_uo[0]);
        for (int i = 0; i < 3; i++) begin
            r_d[i]  <= VEC_W'(w_ui[i]) - VEC_W'(w_uo[i]);
            r_d2[i] <= r_d[i];
            r_h[i]  <= r_hp[2*i] - r_hp[2*i+1];
        end
        r_ok12  <= w_ok1 & w_ok2;
        r_ok12b <= r_ok12;
    end

    //--------------------------------------------------------------------
    // Periapse direction p, unit h
    //--------------------------------------------------------------------
    logic signed [UNIT_W-1:0] w_p  [3];
    logic signed [UNIT_W-1:0] w_hu [3];
    logic                     w_ok3, w_ok4;

    fps_unit u_unit_p (.i_clk(i_clk), .i_c(r_d2), .o_u(w_p),  .o_ok(w_ok3));
    fps_unit u_unit_h (.i_clk(i_clk), .i_c(r_h),  .o_u(w_hu), .o_ok(w_ok4));

    logic r_okdl1 [T_U2-T_C1];
    always_ff @(posedge i_clk) begin
        r_okdl1[0] <= r_ok12b;
        for (int k = 1; k < T_U2 - T_C1; k++) r_okdl1[k] <= r_okdl1[k-1];
    end

    // w = hu x p
    logic signed [VEC_W-1:0] r_wp [6];
    logic signed [VEC_W-1:0] r_w  [3];
    logic                    r_oka, r_okb;

    always_ff @(posedge i_clk) begin
        r_wp[0] <= VEC_W'(w_hu[1]) * VEC_W'(w_p[2]);
        r_wp[1] <= VEC_W'(w_hu[2]) * VEC_W'(w_p[1]);
        r_wp[2] <= VEC_W'(w_hu[2]) * VEC_W'(w_p[0]);
        r_wp[3] <= VEC_W'(w_hu[0]) * VEC_W'(w_p[2]);
        r_wp[4] <= VEC_W'(w_hu[0]) * VEC_W'(w_p[1]);
        r_wp[5] <= VEC_W'(w_hu[1]) * VEC_W'(w_p[0]);
        for (int i = 0; i < 3; i++) r_w[i] <= r_wp[2*i] - r_wp[2*i+1];
        r_oka <= r_okdl1[T_U2-T_C1-1] & w_ok3 & w_ok4;
        r_okb <= r_oka;
    end

    //--------------------------------------------------------------------
    // Velocity direction
    //--------------------------------------------------------------------
    logic signed [UNIT_W-1:0] w_vd [3];
    logic                     w_ok5;

    fps_unit u_unit_v (.i_clk(i_clk), .i_c(r_w), .o_u(w_vd), .o_ok(w_ok5));

    // align p, ok, speed and clamp flag with the velocity direction
    logic signed [UNIT_W-1:0] r_pdl  [T_U3-T_U2][3];
    logic                     r_okdl2 [T_U3-T_C2];
    logic [30:0]              r_spdl [T_U3-T_SPD];
    logic                     r_ngdl [T_U3-T_ARG];

    always_ff @(posedge i_clk) begin
        r_pdl[0]   <= w_p;
        r_okdl2[0] <= r_okb;
        r_spdl[0]  <= r_spd;
        r_ngdl[0]  <= r_arg[63];
        for (int k = 1; k < T_U3 - T_U2; k++)  r_pdl[k]   <= r_pdl[k-1];
        for (int k = 1; k < T_U3 - T_C2; k++)  r_okdl2[k] <= r_okdl2[k-1];
        for (int k = 1; k < T_U3 - T_SPD; k++) r_spdl[k]  <= r_spdl[k-1];
        for (int k = 1; k < T_U3 - T_ARG; k++) r_ngdl[k]  <= r_ngdl[k-1];
    end

    //--------------------------------------------------------------------
    // Scale: pos = r*p/2^14, vel = speed*vd/2^30, rounded half away from zero
    //--------------------------------------------------------------------
    logic [55:0] r_pm [3];
    logic [61:0] r_vm [3];
    logic [2:0]  r_psg, r_vsg;
    logic        r_okf, r_ngf;
    logic [30:0] w_pmag [3];
    logic [30:0] w_vmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pmag[i] = r_pdl[T_U3-T_U2-1][i][UNIT_W-1]
                        ? 31'(-r_pdl[T_U3-T_U2-1][i]) : 31'(r_pdl[T_U3-T_U2-1][i]);
            w_vmag[i] = w_vd[i][UNIT_W-1] ? 31'(-w_vd[i]) : 31'(w_vd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pm[i]  <= 56'(w_rad) * 56'(w_pmag[i]);
            r_vm[i]  <= 62'(r_spdl[T_U3-T_SPD-1]) * 62'(w_vmag[i]);
            r_psg[i] <= r_pdl[T_U3-T_U2-1][i][UNIT_W-1];
            r_vsg[i] <= w_vd[i][UNIT_W-1];
        end
        r_okf <= r_okdl2[T_U3-T_C2-1] & w_ok5;
        r_ngf <= r_ngdl[T_U3-T_ARG-1];
    end

    logic signed [POS_W-1:0] r_pos [3];
    logic signed [V_W-1:0]   r_vel [3];
    t_status                 r_status;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic [POS_W-1:0] pm;
            logic [V_W-1:0]   vm;
            pm = POS_W'((r_pm[i] + 56'd8192) >> 14);
            vm = V_W'((r_vm[i] + 62'h2000_0000) >> 30);
            if (!r_okf) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end else begin
                r_pos[i] <= r_psg[i] ? -pm : pm;
                r_vel[i] <= r_vsg[i] ? -vm : vm;   // speed is zero when clamped
            end
        end
        priority if (!r_okf) r_status <= ST_DEGEN;
        else if (r_ngf)      r_status <= ST_CLAMP;
        else                 r_status <= ST_OK;
    end

    assign o_done       = r_vld[T_OUT];
    assign o_peri_pos_x = r_pos[0];
    assign o_peri_pos_y = r_pos[1];
    assign o_peri_pos_z = r_pos[2];
    assign o_peri_vel_x = r_vel[0];
    assign o_peri_vel_y = r_vel[1];
    assign o_peri_vel_z = r_vel[2];
    assign o_status     = r_status;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("config write did not restart gravity divide");

    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !r_vld[0])
        else $error("transaction taken while busy");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_DEGEN) |->
        (o_peri_pos_x == '0 && o_peri_pos_y == '0 && o_peri_pos_z == '0 &&
         o_peri_vel_x == '0 && o_peri_vel_y == '0 && o_peri_vel_z == '0))
        else $error("degenerate result with nonzero vector");

    a_clamp_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_CLAMP) |->
        (o_peri_vel_x == '0 && o_peri_vel_y == '0 && o_peri_vel_z == '0))
        else $error("clamped root argument with nonzero velocity");

endmodule
`default_nettype wire

// File: design/fps_sqrt.sv
// fps_sqrt: pipelined floor integer square root, one root bit per register stage.
// Depends on fps_pkg for the default radicand width.
`timescale 1ns / 1ps
`default_nettype none
module fps_sqrt #(
    parameter int W = fps_pkg::SQRT_W
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_rad,
    output logic [W/2-1:0] o_root
);
    import fps_pkg::*;

    localparam int K  = W / 2;
    localparam int RW = K + 3;

    logic [RW-1:0] r_rem  [K];
    logic [K-1:0]  r_root [K];
    logic [W-1:0]  r_x    [K-1];

    for (genvar k = 0; k < K; k++) begin : g_stg
        logic [RW-1:0] p_rem;
        logic [K-1:0]  p_root;
        logic [W-1:0]  p_x;
        logic [RW-1:0] sh;
        logic [RW-1:0] trial;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_rad;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
        end

        assign sh    = {p_rem[RW-3:0], p_x[W-1 -: 2]};
        assign trial = RW'({p_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (sh >= trial) begin
                r_rem[k]  <= sh - trial;
                r_root[k] <= {p_root[K-2:0], 1'b1};
            end else begin
                r_rem[k]  <= sh;
                r_root[k] <= {p_root[K-2:0], 1'b0};
            end
        end

        if (k < K - 1) begin : g_x
            always_ff @(posedge i_clk) begin
                r_x[k] <= {p_x[W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[K-1];

endmodule
`default_nettype wire

// File: design/fps_unit.sv
// fps_unit: pipelined unitizer, signed vector in, Q1.30 unit vector and nonzero flag out.
// Depends on fps_pkg and fps_sqrt; fully pipelined, one vector per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fps_unit (
    input  logic                              i_clk,
    input  logic signed [fps_pkg::VEC_W-1:0]  i_c [3],
    output logic signed [fps_pkg::UNIT_W-1:0] o_u [3],
    output logic                              o_ok
);
    import fps_pkg::*;

    localparam int MW     = 63;
    localparam int SIDE_D = 2 + SQRT_LAT;

    // magnitude and normalize: stage 0 holds magnitudes
    logic [MW-1:0] r_nw [NORM_STG+1][3];
    logic [2:0]    r_ng [NORM_STG+1];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_nw[0][i]    <= i_c[i][VEC_W-1] ? MW'(-i_c[i]) : MW'(i_c[i]);
            r_ng[0][i]    <= i_c[i][VEC_W-1];
        end
    end

    for (genvar j = 1; j <= NORM_STG; j++) begin : g_norm
        localparam int SH = 1 << (NORM_STG - j);
        logic [MW-1:0] all_or;
        assign all_or = r_nw[j-1][0] | r_nw[j-1][1] | r_nw[j-1][2];
        always_ff @(posedge i_clk) begin
            r_ng[j] <= r_ng[j-1];
            for (int i = 0; i < 3; i++) begin
                r_nw[j][i] <= (all_or[MW-1 -: SH] == '0) ? (r_nw[j-1][i] << SH)
                                                          : r_nw[j-1][i];
            end
        end
    end

    // leading one now at bit 30 of the kept slice
    logic [30:0] w_m [3];
    always_comb begin
        for (int i = 0; i < 3; i++) w_m[i] = r_nw[NORM_STG][i][MW-1 -: 31];
    end

    // sum of squares
    logic [61:0] r_sqp [3];
    logic [63:0] r_sum;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) r_sqp[i] <= 62'(w_m[i]) * 62'(w_m[i]);
        r_sum <= 64'(r_sqp[0]) + 64'(r_sqp[1]) + 64'(r_sqp[2]);
    end

    logic [SQRT_W/2-1:0] w_n;
    fps_sqrt #(.W(SQRT_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_sum),
        .o_root (w_n)
    );

    // side data waits for the norm
    logic [30:0] r_dm [SIDE_D][3];
    logic [2:0]  r_dn [SIDE_D];
    always_ff @(posedge i_clk) begin
        r_dm[0] <= w_m;
        r_dn[0] <= r_ng[NORM_STG];
        for (int k = 1; k < SIDE_D; k++) begin
            r_dm[k] <= r_dm[k-1];
            r_dn[k] <= r_dn[k-1];
        end
    end

    // numerator with half-divisor rounding
    logic [61:0] r_num [3];
    logic [31:0] r_n0;
    logic [2:0]  r_ng0;
    logic        r_nz0;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_num[i] <= 62'({r_dm[SIDE_D-1][i], 30'b0}) + 62'(w_n >> 1);
        end
        r_n0  <= w_n;
        r_ng0 <= r_dn[SIDE_D-1];
        r_nz0 <= |{r_dm[SIDE_D-1][0], r_dm[SIDE_D-1][1], r_dm[SIDE_D-1][2]};
    end

    // restoring divide, quotient below 2^31 since each component <= norm
    logic [31:0] r_dr  [DIV_STG-1][3];
    logic [30:0] r_dlo [DIV_STG-1][3];
    logic [30:0] r_dq  [DIV_STG][3];
    logic [31:0] r_dn_ [DIV_STG-1];
    logic [2:0]  r_dsg [DIV_STG];
    logic        r_dnz [DIV_STG];

    for (genvar j = 0; j < DIV_STG; j++) begin : g_div
        logic [31:0] p_r  [3];
        logic [30:0] p_lo [3];
        logic [30:0] p_q  [3];
        logic [31:0] p_n;
        logic [2:0]  p_sg;
        logic        p_nz;
        logic [32:0] t    [3];
        logic        qb   [3];
        logic [31:0] rn   [3];

        if (j == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    p_r[i]  = {1'b0, r_num[i][61:31]};
                    p_lo[i] = r_num[i][30:0];
                    p_q[i]  = '0;
                end
            end
            assign p_n  = r_n0;
            assign p_sg = r_ng0;
            assign p_nz = r_nz0;
        end else begin : g_next
            assign p_r  = r_dr[j-1];
            assign p_lo = r_dlo[j-1];
            assign p_q  = r_dq[j-1];
            assign p_n  = r_dn_[j-1];
            assign p_sg = r_dsg[j-1];
            assign p_nz = r_dnz[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                t[i]  = {p_r[i], p_lo[i][DIV_STG-1-j]};
                qb[i] = (t[i] >= {1'b0, p_n});
                rn[i] = qb[i] ? 32'(t[i] - {1'b0, p_n}) : t[i][31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) r_dq[j][i] <= {p_q[i][29:0], qb[i]};
            r_dsg[j] <= p_sg;
            r_dnz[j] <= p_nz;
        end

        if (j < DIV_STG - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_dr[j]  <= rn;
                r_dlo[j] <= p_lo;
                r_dn_[j] <= p_n;
            end
        end
    end

    // clamp, sign, zero on an all-zero vector
    logic signed [UNIT_W-1:0] r_u [3];
    logic                     r_ok;
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            logic [30:0] qc;
            qc = (r_dq[DIV_STG-1][i] > ONE_Q30) ? ONE_Q30 : r_dq[DIV_STG-1][i];
            if (!r_dnz[DIV_STG-1]) r_u[i] <= '0;
            else if (r_dsg[DIV_STG-1][i]) r_u[i] <= -UNIT_W'(qc);
            else r_u[i] <= UNIT_W'(qc);
        end
        r_ok <= r_dnz[DIV_STG-1];
    end

    assign o_u  = r_u;
    assign o_ok = r_ok;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking testbench for flyby_periapse_state.
// Depends on fps_pkg and the flyby_periapse_state RTL; needs nothing else.
`timescale 1ns / 1ps
module tb_top;
    import fps_pkg::*;

    // Unused register index: a write to it must leave every register as it was.
    localparam logic [IDX_W-1:0] CFG_NONE = 2'd3;
    // Cycles without any transaction before the run is declared hung.
    // Covers the gravity divide, the pipeline and the longest gap.
    localparam int HANG_LIMIT = 3000;

    typedef logic [V_W-1:0] t_vec6 [6];   // vin x/y/z, vout x/y/z

    typedef struct packed {
        logic [POS_W-1:0] pos_x, pos_y, pos_z;
        logic [V_W-1:0]   vel_x, vel_y, vel_z;
        t_status          status;
    } t_periapse;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_cfg_we = 1'b0;
    logic [IDX_W-1:0]         i_cfg_idx = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic signed [V_W-1:0]    vin_x = '0, vin_y = '0, vin_z = '0;
    logic signed [V_W-1:0]    vout_x = '0, vout_y = '0, vout_z = '0;
    logic                     o_done;
    logic signed [POS_W-1:0]  o_peri_pos_x, o_peri_pos_y, o_peri_pos_z;
    logic signed [V_W-1:0]    o_peri_vel_x, o_peri_vel_y, o_peri_vel_z;
    logic [1:0]               o_status;

    flyby_periapse_state i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_vin_x      (vin_x),
        .i_vin_y      (vin_y),
        .i_vin_z      (vin_z),
        .i_vout_x     (vout_x),
        .i_vout_y     (vout_y),
        .i_vout_z     (vout_z),
        .o_done       (o_done),
        .o_peri_pos_x (o_peri_pos_x),
        .o_peri_pos_y (o_peri_pos_y),
        .o_peri_pos_z (o_peri_pos_z),
        .o_peri_vel_x (o_peri_vel_x),
        .o_peri_vel_y (o_peri_vel_y),
        .o_peri_vel_z (o_peri_vel_z),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the config registers, updated as writes are issued.
    longint unsigned grav_param_q  = 398600;
    longint unsigned body_rad_q    = 6378;
    longint unsigned flyby_alt_q   = 300;

    t_periapse pending_periapse[$];   // predicted results, oldest first
    int        n_mismatch = 0;
    bit        idle_enable = 1'b1;    // sender gaps on/off

    // ---------------------------------------------------------------
    // Periapse predictor (bit exact, 64-bit integer arithmetic)
    // ---------------------------------------------------------------
    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q1.30 unit vector; magnitudes normalized into [2^30, 2^31) first.
    // Returns 0 for a zero vector (u is then all zero).
    function automatic bit to_unit(input longint c[3], output longint u[3]);
        longint unsigned m[3];
        longint unsigned top, sq, n, q;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(c[i]);
            if (m[i] > top) top = m[i];
            u[i] = 0;
        end
        if (top == 0) return 1'b0;
        while (top >= (64'd1 << 31)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (top < (64'd1 << 30)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        n  = floor_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + n / 2) / n;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_prod(input longint a[3], input longint b[3],
                                       output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // a*u/2^sh, half away from zero
    function automatic longint scale_round(longint unsigned a, longint u, int sh);
        longint unsigned p;
        p = (a * mag(u) + (64'd1 << (sh - 1))) >> sh;
        return u < 0 ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint quarter_floor(longint x);
        if (x < 0) return -longint'((mag(x) + 3) >> 2);
        return longint'(unsigned'(x) >> 2);
    endfunction

    function automatic t_periapse predict_periapse(t_vec6 v);
        longint vi[3], vo[3], ui[3], uo[3], d[3], h[3], hu[3], p[3], w[3], vd[3];
        longint pos[3], vel[3], arg;
        longint unsigned r, dv, grav, speed;
        t_status st;
        bit ok;
        t_periapse e;
        speed = 0;
        st = ST_OK;
        for (int i = 0; i < 3; i++) begin
            vi[i] = longint'(signed'(v[i]));
            vo[i] = longint'(signed'(v[3 + i]));
            pos[i] = 0;
            vel[i] = 0;
        end
        ok = to_unit(vi, ui);
        ok = to_unit(vo, uo) && ok;
        if (ok) begin
            for (int i = 0; i < 3; i++) d[i] = ui[i] - uo[i];
            ok = to_unit(d, p);
        end
        if (ok) begin
            cross_prod(ui, uo, h);
            ok = to_unit(h, hu);
        end
        if (ok) begin
            cross_prod(hu, p, w);
            ok = to_unit(w, vd);
        end
        if (!ok) begin
            // degenerate direction wins over a clamped root argument
            st = ST_DEGEN;
        end else begin
            r    = body_rad_q + flyby_alt_q;
            dv   = (r == 0) ? 1 : r;
            grav = ((grav_param_q * 2) << 32) / dv;
            arg  = longint'(grav >> 2);
            for (int i = 0; i < 3; i++) arg += quarter_floor(vi[i] * vo[i]);
            if (arg < 0) begin
                st = ST_CLAMP;
            end else begin
                speed = floor_sqrt(unsigned'(arg) * 4);
                if (speed > 64'h7FFF_FFFF) speed = 64'h7FFF_FFFF;
            end
            for (int i = 0; i < 3; i++) begin
                pos[i] = scale_round(r, p[i], 14);
                vel[i] = scale_round(speed, vd[i], 30);
            end
        end
        e.pos_x  = pos[0][POS_W-1:0];
        e.pos_y  = pos[1][POS_W-1:0];
        e.pos_z  = pos[2][POS_W-1:0];
        e.vel_x  = vel[0][V_W-1:0];
        e.vel_y  = vel[1][V_W-1:0];
        e.vel_z  = vel[2][V_W-1:0];
        e.status = st;
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    // One transaction: drive at the falling edge, hold until accepted.
    // start stays high on return; the caller's next negedge action decides.
    task automatic send_flyby(t_vec6 v);
        @(negedge i_clk);
        {vin_x, vin_y, vin_z}    = {v[0], v[1], v[2]};
        {vout_x, vout_y, vout_z} = {v[3], v[4], v[5]};
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_periapse = {pending_periapse, predict_periapse(v)};
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Send with an occasional random gap afterwards.
    task automatic send_gapped(t_vec6 v);
        send_flyby(v);
        if (idle_enable && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 11));
    endtask

    // Drop start, drain every outstanding result, then let the pipe settle.
    task automatic drain_pipe();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_periapse.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain_pipe();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_GRAV_PARAM: grav_param_q = val[GP_W-1:0];
            CFG_BODY_RAD:   body_rad_q   = val[RAD_W-1:0];
            CFG_FLYBY_ALT:  flyby_alt_q  = val[RAD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [V_W-1:0] rand_comp(int sz);
        case (sz)
            0: return $urandom();
            1: return V_W'(int'($urandom_range(0, 2 * 1048576)) - 1048576);   // |v| <= 16 km/s
            default: return V_W'(int'($urandom_range(0, 2 * 65536)) - 65536);  // |v| <= 1 km/s
        endcase
    endfunction

    // Mostly plausible flybys with random content, plus corner shapes.
    function automatic t_vec6 rand_flyby();
        t_vec6 v;
        int kind, sz;
        kind = $urandom_range(0, 15);
        sz   = $urandom_range(0, 2);
        for (int i = 0; i < 6; i++) v[i] = rand_comp(sz);
        case (kind)
            0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];                 // parallel
            1: for (int i = 0; i < 3; i++) v[3 + i] = -v[i];                // antiparallel
            2: for (int i = 0; i < 3; i++) v[3 + i] = v[i] << 1;            // scaled copy
            3: v[$urandom_range(0, 5)] = '0;                                // axis-plane case
            4: begin                                                        // zero vector
                v[0] = '0; v[1] = '0; v[2] = '0;
            end
            5: for (int i = 0; i < 6; i++) v[i] = $urandom_range(0, 1) ? 32'h8000_0000
                                                                      : 32'h7FFF_FFFF;
            6: for (int i = 0; i < 3; i++) v[3 + i] = -v[i] + V_W'($urandom_range(0, 64));
            default: ;
        endcase
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        t_vec6 v;
        v = '{default: 32'h7FFF_FFFF};                               send_flyby(v);
        v = '{default: 32'h8000_0000};                               send_flyby(v);
        v = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};             send_flyby(v);
        v = '{0, 0, 0, 32'h0001_0000, 0, 0};                         send_flyby(v); // vin zero
        v = '{32'h0001_0000, 0, 0, 0, 0, 0};                         send_flyby(v); // vout zero
        v = '{32'h0005_0000, 32'h0003_0000, 0, 32'h0005_0000, 32'h0003_0000, 0};
        send_flyby(v);                                                             // in == out
        v = '{32'h0005_0000, 0, 0, 32'hFFFB_0000, 0, 0};             send_flyby(v); // reversal
        v = '{32'h000B_0000, 0, 0, 32'hFFF6_0000, 32'h0002_0000, 0};
        send_flyby(v);                                                             // negative dot product
        v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};          send_flyby(v);
        v = '{32'h0000_0001, 0, 0, 0, 32'h0000_0001, 0};             send_flyby(v); // tiny
        v = '{32'h0003_8000, 32'hFFFE_0000, 32'h0001_4000,
              32'hFFFD_0000, 32'h0002_8000, 32'h0004_0000};          send_flyby(v);
        for (int k = 0; k < 8; k++) send_gapped(rand_flyby());
    endtask

    task automatic test_cfg_sweep();
        logic [CFG_W-1:0] gp_set [7] = '{28'd0, 28'hFFF_FFFF, 28'd398600, 28'd126686534,
                                         28'd4903, 28'd37931187, 28'd1};
        logic [CFG_W-1:0] rad_set[7] = '{24'd1, 24'hFF_FFFF, 24'd1, 24'd71492,
                                         24'd1737, 24'd60268, 24'hFF_FFFF};
        logic [CFG_W-1:0] alt_set[7] = '{24'd0, 24'hFF_FFFF, 24'd0, 24'd500000,
                                         24'd100, 24'd0, 24'd12345};
        for (int s = 0; s < 7; s++) begin
            write_cfg(CFG_GRAV_PARAM, gp_set[s]);
            write_cfg(CFG_BODY_RAD, rad_set[s]);
            write_cfg(CFG_FLYBY_ALT, alt_set[s]);
            if (s == 2) write_cfg(CFG_NONE, 28'hABC_DEF0);   // must be ignored
            for (int k = 0; k < 130; k++) send_gapped(rand_flyby());
        end
    endtask

    // Back-to-back stream at full rate, default-like body.
    task automatic test_stream();
        write_cfg(CFG_GRAV_PARAM, 28'd398600);
        write_cfg(CFG_BODY_RAD, 24'd6378);
        write_cfg(CFG_FLYBY_ALT, 24'd300);
        idle_enable = 1'b0;
        for (int k = 0; k < 520; k++) send_flyby(rand_flyby());
    endtask

    // ---------------------------------------------------------------
    // Result checker: every o_done pulse is one transaction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_periapse got, want;
        if (i_rst_n && o_done) begin
            got = '{o_peri_pos_x, o_peri_pos_y, o_peri_pos_z,
                    o_peri_vel_x, o_peri_vel_y, o_peri_vel_z, o_status};
            if (pending_periapse.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_periapse.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Hang detector: cycles with no accepted transaction either way
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_cfg_sweep();
        test_stream();
        drain_pipe();
        if (n_mismatch == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
